// ----- hw/rtl/infix_to_postfix_converter_core_macros.svh -----
// assertion macros shared by the converter rtl
// each check is clocked on aclk and held off while aresetn is low
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// condition holds on every cycle out of reset
`define IP2P_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define IP2P_CHECK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IP2P_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ip2p_pkg.sv -----
// ----------------------------------------------------------------------------
// ip2p_pkg
// shared types, character codes and precedence lookup for the converter
// ----------------------------------------------------------------------------
package ip2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int SIDX_W      = $clog2(STACK_DEPTH);
    localparam int SCNT_W      = $clog2(STACK_DEPTH + 1);

    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef logic [1:0] prec_t;

    localparam prec_t PREC_NONE = 2'd0;
    localparam prec_t PREC_ADD  = 2'd1;
    localparam prec_t PREC_MUL  = 2'd2;
    localparam prec_t PREC_POW  = 2'd3;

    typedef enum logic [1:0] {
        CLS_OPERAND,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER
    } sym_class_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expr;
    } s_word_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       symbol_valid;
        logic       last_of_expr;
        logic       error;
    } m_word_t;

    typedef struct packed {
        logic [7:0] symbol;
        sym_class_t cls;
        prec_t      prec;
        logic       last;
    } cls_item_t;

    function automatic prec_t prec_of(input logic [7:0] c);
        prec_t p;
        case (c)
            CH_CARET:          p = PREC_POW;
            CH_STAR, CH_SLASH: p = PREC_MUL;
            CH_PLUS, CH_MINUS: p = PREC_ADD;
            default:           p = PREC_NONE;
        endcase
        return p;
    endfunction

endpackage

// ----- hw/rtl/infix_to_postfix_converter_core.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// shunting-yard infix to postfix converter, one character per input word
// ----------------------------------------------------------------------------
// Feed one ASCII character of an infix expression per input word and set
// end_of_expr on its last character; postfix characters come out one per
// output word, the final word of an expression carrying last_of_expr (an
// expression that yields nothing gives one word with symbol_valid low and
// out_symbol zero). Operands pass straight through, parentheses group, and
// ^ (highest), * / and + - (lowest) all associate to the left. A close paren
// without its open paren, or a push onto a full 32-entry stack, raises error on
// every word of that character and of the rest of the expression; the flag and
// the stack clear at the end of each expression. A 2-entry queue lets
// the input side keep taking words while the stack engine works. The engine
// picks up a character and then pops or emits one entry per cycle while the
// output is free: an operand is emitted, '(' is pushed, an operator first pops
// the stacked operators of equal or higher rank and ')' those down to its '(',
// and an end-of-expression character then flushes the stack and sends the
// closing word. Output backpressure holds the emits.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core (
    input  logic              aclk,
    input  logic              aresetn,
    // input character words
    input  logic              s_valid,
    output logic              s_ready,
    input  ip2p_pkg::s_word_t s_word,
    // postfix result words
    output logic              m_valid,
    input  logic              m_ready,
    output ip2p_pkg::m_word_t m_word
);
    import ip2p_pkg::*;

    // classified characters between the front and the stack engine
    logic      fifo_wr_en;
    cls_item_t fifo_wr_item;
    logic      fifo_full;
    logic      fifo_rd_en;
    logic      fifo_rd_valid;
    cls_item_t fifo_rd_item;

    // front: takes input words and tags each as operand, paren or operator
    ip2p_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .fifo_full (fifo_full),
        .wr_en     (fifo_wr_en),
        .wr_item   (fifo_wr_item)
    );

    // decoupling queue so the input side does not wait on long pop runs
    ip2p_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (fifo_wr_en),
        .wr_item  (fifo_wr_item),
        .full     (fifo_full),
        .rd_en    (fifo_rd_en),
        .rd_valid (fifo_rd_valid),
        .rd_item  (fifo_rd_item)
    );

    // back: operator stack, pops and flush, registered output word
    ip2p_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (fifo_rd_valid),
        .q_item  (fifo_rd_item),
        .q_pop   (fifo_rd_en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

// ----- hw/rtl/ip2p_front.sv -----
// ----------------------------------------------------------------------------
// ip2p_front
// input word acceptance and character classification into the queue
// ----------------------------------------------------------------------------
module ip2p_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  ip2p_pkg::s_word_t   s_word,
    input  logic                fifo_full,
    output logic                wr_en,
    output ip2p_pkg::cls_item_t wr_item
);
    import ip2p_pkg::*;

    prec_t p;

    assign s_ready = !fifo_full;
    assign wr_en   = s_valid && !fifo_full;
    assign p       = prec_of(s_word.symbol);

    always_comb begin
        wr_item.symbol = s_word.symbol;
        wr_item.prec   = p;
        wr_item.last   = s_word.end_of_expr;
        if (s_word.symbol == CH_LPAREN) begin
            wr_item.cls = CLS_OPEN;
        end else if (s_word.symbol == CH_RPAREN) begin
            wr_item.cls = CLS_CLOSE;
        end else if (p != PREC_NONE) begin
            wr_item.cls = CLS_OPER;
        end else begin
            wr_item.cls = CLS_OPERAND;
        end
    end

endmodule

// ----- hw/rtl/ip2p_fifo.sv -----
// ----------------------------------------------------------------------------
// ip2p_fifo
// short queue of classified characters between front and back
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_macros.svh"

module ip2p_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  ip2p_pkg::cls_item_t wr_item,
    output logic                full,
    input  logic                rd_en,
    output logic                rd_valid,
    output ip2p_pkg::cls_item_t rd_item
);
    import ip2p_pkg::*;

    cls_item_t         mem_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] cnt_reg,    cnt_next;

    assign full     = (cnt_reg == FCNT_W'(FIFO_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + FPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + FPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + FCNT_W'(1);
        end else if (!wr_en && rd_en) begin
            cnt_next = cnt_reg - FCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `IP2P_CHECK_IMPL(a_no_write_when_full, wr_en, !full, "queue written while full")
    `IP2P_CHECK_IMPL(a_no_read_when_empty, rd_en, rd_valid, "queue read while empty")

endmodule

// ----- hw/rtl/ip2p_back.sv -----
// ----------------------------------------------------------------------------
// ip2p_back
// operator stack engine and output word register
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_macros.svh"

module ip2p_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  ip2p_pkg::cls_item_t q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ip2p_pkg::m_word_t   m_word
);
    import ip2p_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_FLUSH
    } state_t;

    state_t            state_reg, state_next;
    cls_item_t         cur_reg, cur_next;
    logic [SCNT_W-1:0] cnt_reg, cnt_next;
    logic [SCNT_W-1:0] open_reg, open_next;
    logic              err_reg, err_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_sym_reg, pend_sym_next;
    logic              out_valid_reg, out_valid_next;
    m_word_t           out_word_reg, out_word_next;

    logic [7:0]        stack_mem [STACK_DEPTH];
    logic              stack_we;
    logic [SIDX_W-1:0] stack_widx;

    logic [SCNT_W-1:0] cnt_dec;
    logic [SIDX_W-1:0] top_idx;
    logic [7:0]        top_sym;
    prec_t             top_prec;
    logic              stack_empty;
    logic              stack_full;
    logic              out_free;
    logic              do_emit;
    logic [7:0]        emit_sym;

    assign cnt_dec     = cnt_reg - SCNT_W'(1);
    assign top_idx     = cnt_dec[SIDX_W-1:0];
    assign top_sym     = stack_mem[top_idx];
    assign top_prec    = prec_of(top_sym);
    assign stack_empty = (cnt_reg == '0);
    assign stack_full  = (cnt_reg == SCNT_W'(STACK_DEPTH));
    assign out_free    = !out_valid_reg || m_ready;
    assign stack_widx  = cnt_reg[SIDX_W-1:0];

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        open_next       = open_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        q_pop           = 1'b0;
        stack_we        = 1'b0;
        do_emit         = 1'b0;
        emit_sym        = top_sym;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    state_next = ST_WORK;
                    // a close paren with nothing open is known bad before any pop
                    if (q_item.cls == CLS_CLOSE && open_reg == '0) begin
                        err_next = 1'b1;
                    end
                end
            end
            ST_WORK: begin
                case (cur_reg.cls)
                    CLS_OPERAND: begin
                        if (out_free) begin
                            do_emit    = 1'b1;
                            emit_sym   = cur_reg.symbol;
                            state_next = cur_reg.last ? ST_FLUSH : ST_IDLE;
                        end
                    end
                    CLS_OPEN: begin
                        if (stack_full) begin
                            err_next = 1'b1;
                        end else begin
                            stack_we  = 1'b1;
                            cnt_next  = cnt_reg + SCNT_W'(1);
                            open_next = open_reg + SCNT_W'(1);
                        end
                        state_next = cur_reg.last ? ST_FLUSH : ST_IDLE;
                    end
                    CLS_CLOSE: begin
                        if (stack_empty) begin
                            state_next = cur_reg.last ? ST_FLUSH : ST_IDLE;
                        end else if (top_sym == CH_LPAREN) begin
                            cnt_next   = cnt_dec;
                            open_next  = open_reg - SCNT_W'(1);
                            state_next = cur_reg.last ? ST_FLUSH : ST_IDLE;
                        end else if (out_free) begin
                            do_emit  = 1'b1;
                            cnt_next = cnt_dec;
                        end
                    end
                    CLS_OPER: begin
                        if (!stack_empty && top_prec >= cur_reg.prec) begin
                            if (out_free) begin
                                do_emit  = 1'b1;
                                cnt_next = cnt_dec;
                            end
                        end else begin
                            if (stack_full) begin
                                err_next = 1'b1;
                            end else begin
                                stack_we = 1'b1;
                                cnt_next = cnt_reg + SCNT_W'(1);
                            end
                            state_next = cur_reg.last ? ST_FLUSH : ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FLUSH: begin
                if (out_free) begin
                    if (!stack_empty) begin
                        do_emit  = 1'b1;
                        cnt_next = cnt_dec;
                        // a leftover open paren leaves the open count as well
                        if (top_sym == CH_LPAREN) begin
                            open_next = open_reg - SCNT_W'(1);
                        end
                    end else begin
                        // held-back word goes out flagged last, or the empty marker
                        out_valid_next = 1'b1;
                        if (pend_valid_reg) begin
                            out_word_next = '{pend_sym_reg, 1'b1, 1'b1, err_reg};
                        end else begin
                            out_word_next = '{8'h00, 1'b0, 1'b1, err_reg};
                        end
                        pend_valid_next = 1'b0;
                        err_next        = 1'b0;
                        cnt_next        = '0;
                        open_next       = '0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // on a final character each word is held back until the next one, so the last one can be flagged
        if (do_emit) begin
            if (cur_reg.last) begin
                pend_valid_next = 1'b1;
                pend_sym_next   = emit_sym;
                if (pend_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{pend_sym_reg, 1'b1, 1'b0, err_reg};
                end
            end else begin
                out_valid_next = 1'b1;
                out_word_next  = '{emit_sym, 1'b1, 1'b0, err_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            open_reg       <= '0;
            err_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            open_reg       <= open_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        cur_reg      <= cur_next;
        pend_sym_reg <= pend_sym_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_widx] <= cur_reg.symbol;
        end
    end

    `IP2P_CHECK(a_cnt_in_range, cnt_reg <= SCNT_W'(STACK_DEPTH), "stack count beyond depth")
    `IP2P_CHECK(a_open_le_cnt, open_reg <= cnt_reg, "open paren count exceeds stack count")
    `IP2P_CHECK_NEXT(a_flush_clears,
        state_reg == ST_FLUSH && out_free && stack_empty,
        cnt_reg == '0 && !err_reg && !pend_valid_reg && state_reg == ST_IDLE,
        "expression end did not leave a clean state")

endmodule

// ----- sim/infix_to_postfix_converter_checker.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_checker
// watches both channels, predicts postfix words and compares them in order
// ----------------------------------------------------------------------------
// Every accepted input word goes through a shunting-yard predictor with its
// own operator stack. The words it predicts wait in a queue, and each
// accepted output word is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_checker
    import ip2p_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  s_word_t     s_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  m_word_t     m_word,
    output int unsigned fail_count,
    output int unsigned words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  op_stack [STACK_DEPTH];
    int unsigned op_depth;
    logic        expr_error;
    m_word_t     postfix_q [$];
    int unsigned mismatches;

    initial begin
        fail_count = 0;
        words_due  = 0;
        mismatches = 0;
        op_depth   = 0;
        expr_error = 1'b0;
    end

    function automatic sym_class_t classify(input logic [7:0] c);
        case (c)
            CH_LPAREN: return CLS_OPEN;
            CH_RPAREN: return CLS_CLOSE;
            CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS: return CLS_OPER;
            default: return CLS_OPERAND;
        endcase
    endfunction

    // binding strength, zero for the open paren so it stops every pop
    function automatic int rank(input logic [7:0] c);
        case (c)
            CH_CARET:          return 3;
            CH_STAR, CH_SLASH: return 2;
            CH_PLUS, CH_MINUS: return 1;
            default:           return 0;
        endcase
    endfunction

    function automatic m_word_t char_word(input logic [7:0] c);
        return '{out_symbol: c, symbol_valid: 1'b1, last_of_expr: 1'b0, error: 1'b0};
    endfunction

    function automatic void push_op(input logic [7:0] c);
        if (op_depth >= STACK_DEPTH) begin
            expr_error = 1'b1;
        end else begin
            op_stack[op_depth] = c;
            op_depth++;
        end
    endfunction

    function automatic void convert_symbol(input s_word_t w);
        m_word_t    step_q [$];
        logic [7:0] top;
        logic       matched;
        matched = 1'b0;
        case (classify(w.symbol))
            CLS_OPEN: begin
                push_op(w.symbol);
            end
            CLS_CLOSE: begin
                while (op_depth > 0 && !matched) begin
                    op_depth--;
                    top = op_stack[op_depth];
                    if (top == CH_LPAREN) begin
                        matched = 1'b1;
                    end else begin
                        step_q.push_back(char_word(top));
                    end
                end
                if (!matched) begin
                    expr_error = 1'b1;
                end
            end
            CLS_OPER: begin
                while (op_depth > 0 && rank(op_stack[op_depth - 1]) >= rank(w.symbol)) begin
                    op_depth--;
                    step_q.push_back(char_word(op_stack[op_depth]));
                end
                push_op(w.symbol);
            end
            default: begin
                step_q.push_back(char_word(w.symbol));
            end
        endcase
        if (w.end_of_expr) begin
            while (op_depth > 0) begin
                op_depth--;
                step_q.push_back(char_word(op_stack[op_depth]));
            end
            if (step_q.size() == 0) begin
                step_q.push_back('{out_symbol: 8'h00, symbol_valid: 1'b0,
                                   last_of_expr: 1'b0, error: 1'b0});
            end
            step_q[step_q.size() - 1].last_of_expr = 1'b1;
        end
        foreach (step_q[i]) begin
            step_q[i].error = expr_error;
            postfix_q.push_back(step_q[i]);
        end
        if (w.end_of_expr) begin
            expr_error = 1'b0;
            op_depth   = 0;
        end
    endfunction

    function automatic void note_failure(input string what, input m_word_t got,
                                         input m_word_t want);
        if (mismatches < 10) begin
            $display("%t %s: got sym %02h valid %b last %b err %b, want sym %02h valid %b last %b err %b",
                     $realtime, what, got.out_symbol, got.symbol_valid, got.last_of_expr,
                     got.error, want.out_symbol, want.symbol_valid, want.last_of_expr,
                     want.error);
        end
        mismatches++;
    endfunction

    always @(posedge aclk) begin
        m_word_t want;
        if (!aresetn) begin
            op_depth   = 0;
            expr_error = 1'b0;
            postfix_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                convert_symbol(s_word);
            end
            if (m_valid && m_ready) begin
                if (postfix_q.size() == 0) begin
                    note_failure("unexpected word", m_word, '0);
                end else begin
                    want = postfix_q.pop_front();
                    if (m_word.out_symbol !== want.out_symbol
                            || m_word.symbol_valid !== want.symbol_valid
                            || m_word.last_of_expr !== want.last_of_expr
                            || m_word.error !== want.error) begin
                        note_failure("word mismatch", m_word, want);
                    end
                end
            end
        end
        fail_count <= mismatches;
        words_due  <= postfix_q.size();
    end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the infix to postfix converter
// ----------------------------------------------------------------------------
// A directed run covers operand extremes, every operator, grouping, left
// associativity, unmatched close parens, leftover open parens and the empty
// end marker. Random expressions follow: mostly well-formed with random
// content, some broken, some raw noise, and deep nestings that can overflow the
// operator stack. Both channels idle at random; a checker beside the block
// predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb;
    import ip2p_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT   = 27;
    localparam int ITEM_COUNT = 410;

    localparam logic [7:0] OPERATORS [5] = '{CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS};

    typedef enum {
        EXPR_CLEAN,
        EXPR_BROKEN,
        EXPR_NOISE,
        EXPR_DEEP
    } expr_kind_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    s_word_t     s_word  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    m_word_t     m_word;
    int unsigned fail_count;
    int unsigned words_due;

    // no random idling on either side while this is set
    logic        calm = 1'b0;

    // characters of the expression being built
    logic [7:0]  expr_q [$];

    infix_to_postfix_converter_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    infix_to_postfix_converter_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // output side stalls at random, never while calm
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // offer one word and hold it until taken; idle gaps only before valid rises
    task automatic push_word(input logic [7:0] sym, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= '{symbol: sym, end_of_expr: last};
        do @(posedge aclk); while (!s_ready);
    endtask

    // mostly letters, now and then any byte that is not an operator or paren
    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(99) < 80) begin
            c = 8'($urandom_range(8'h7a, 8'h61));
        end else begin
            c = 8'($urandom_range(255));
        end
        while (c inside {CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS,
                         CH_LPAREN, CH_RPAREN}) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        return OPERATORS[$urandom_range(4)];
    endfunction

    // well-formed grammar: expr is term (op term)*, term is operand or (expr)
    function automatic void build_term(input int depth);
        if (depth < 4 && $urandom_range(99) < 30) begin
            expr_q.push_back(CH_LPAREN);
            build_expr(depth + 1);
            expr_q.push_back(CH_RPAREN);
        end else begin
            expr_q.push_back(pick_operand());
        end
    endfunction

    function automatic void build_expr(input int depth);
        build_term(depth);
        repeat ($urandom_range(3)) begin
            expr_q.push_back(pick_operator());
            build_term(depth);
        end
    endfunction

    // nesting that can run past the stack, then up to as many closes as opens
    function automatic void build_deep();
        int levels;
        levels = $urandom_range(40, 28);
        repeat (levels) begin
            expr_q.push_back(CH_LPAREN);
            if ($urandom_range(3) == 0) begin
                expr_q.push_back(pick_operand());
                expr_q.push_back(pick_operator());
            end
        end
        expr_q.push_back(pick_operand());
        repeat ($urandom_range(levels)) expr_q.push_back(CH_RPAREN);
        expr_q.push_back(pick_operand());
    endfunction

    // a clean expression with one flaw: stray close, lost char or extra operator
    function automatic void break_expr();
        int pos;
        pos = $urandom_range(expr_q.size() - 1);
        case ($urandom_range(2))
            0: expr_q.insert(pos, CH_RPAREN);
            1: if (expr_q.size() > 1) expr_q.delete(pos);
            default: expr_q.insert(pos, pick_operator());
        endcase
    endfunction

    function automatic expr_kind_t pick_kind(input int unsigned idx);
        int roll;
        roll = $urandom_range(99);
        if (idx == 1) return EXPR_DEEP;
        if (roll < 60) return EXPR_CLEAN;
        if (roll < 73) return EXPR_BROKEN;
        if (roll < 88) return EXPR_NOISE;
        return EXPR_DEEP;
    endfunction

    initial begin
        int unsigned sent;
        int unsigned expr_idx;
        expr_kind_t  kind;
        logic        noise_end;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // operand extremes, minus, slash and a left-leaning caret chain
        push_word(8'h00, 1'b0);
        push_word(CH_MINUS, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(CH_SLASH, 1'b0);
        push_word("x", 1'b0);
        push_word(CH_CARET, 1'b0);
        push_word("y", 1'b0);
        push_word(CH_CARET, 1'b0);
        push_word("z", 1'b1);
        // grouping with plus and star
        push_word(CH_LPAREN, 1'b0);
        push_word("a", 1'b0);
        push_word(CH_PLUS, 1'b0);
        push_word("b", 1'b0);
        push_word(CH_RPAREN, 1'b0);
        push_word(CH_STAR, 1'b0);
        push_word("c", 1'b1);
        // close paren on an empty stack, then one that has to drain a plus
        push_word(CH_RPAREN, 1'b0);
        push_word("q", 1'b0);
        push_word(CH_PLUS, 1'b0);
        push_word(CH_RPAREN, 1'b0);
        push_word("r", 1'b1);
        // open parens still stacked at the end get flushed out
        push_word(CH_LPAREN, 1'b0);
        push_word(CH_LPAREN, 1'b1);
        // matched pair and nothing else: only the empty marker comes out
        push_word(CH_LPAREN, 1'b0);
        push_word(CH_RPAREN, 1'b1);

        sent     = 0;
        expr_idx = 0;
        while (sent < ITEM_COUNT) begin
            // a stretch in the middle runs with no idling on either side
            calm <= (sent >= 150 && sent < 260);
            kind = pick_kind(expr_idx);
            expr_q.delete();
            case (kind)
                EXPR_CLEAN: build_expr(0);
                EXPR_BROKEN: begin
                    build_expr(0);
                    break_expr();
                end
                EXPR_NOISE: begin
                    repeat ($urandom_range(6, 1)) expr_q.push_back(8'($urandom_range(255)));
                end
                default: build_deep();
            endcase
            foreach (expr_q[i]) begin
                // noise may close early, every expression closes on its last char
                noise_end = (kind == EXPR_NOISE) && $urandom_range(1);
                push_word(expr_q[i], noise_end || (i == expr_q.size() - 1));
            end
            sent += expr_q.size();
            expr_idx++;
        end
        s_valid <= 1'b0;
        calm    <= 1'b0;

        // let the last prediction land, then drain and let stragglers show
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        if (fail_count == 0 && words_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ip2p_pkg.sv
hw/rtl/ip2p_front.sv
hw/rtl/ip2p_fifo.sv
hw/rtl/ip2p_back.sv
hw/rtl/infix_to_postfix_converter_core.sv
sim/infix_to_postfix_converter_checker.sv
sim/tb.sv
